@@ hw/rtl/crd_pkg.sv @@
package crd_pkg;

  localparam int unsigned NumSections = 5;

  typedef enum logic [1:0] {
    MODE_NAME    = 2'd0,
    MODE_OPTIONS = 2'd1,
    MODE_COUNT   = 2'd2,
    MODE_PAYLOAD = 2'd3
  } mode_t;

  localparam logic [2:0] PH_NAME     = 3'd0;
  localparam logic [2:0] PH_NAME_END = 3'd1;
  localparam logic [2:0] PH_OPTIONS  = 3'd2;
  localparam logic [2:0] PH_COUNT_HI = 3'd3;
  localparam logic [2:0] PH_COUNT_LO = 3'd4;
  localparam logic [2:0] PH_PAYLOAD  = 3'd5;

  localparam logic [2:0] SEC_STMT_SINGLE = 3'd0;
  localparam logic [2:0] SEC_STMT_COUNT  = 3'd1;
  localparam logic [2:0] SEC_MCDC        = 3'd3;
  localparam logic [2:0] SEC_NONE        = 3'(NumSections);

  localparam logic [1:0] CNT_HI = 2'd2;
  localparam logic [1:0] CNT_LO = 2'd1;

  localparam logic [17:0] MCDC_EXTRA = 18'd2;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  count_bytes_left;
    logic [17:0] bytes_left;
    logic [4:0]  enabled_sections;
    logic [2:0]  current_section;
  } state_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] phase;
    logic [2:0] section;
    logic       section_end;
    logic       record_end;
  } result_t;

  // lowest enabled section at or above start, SEC_NONE if none
  function automatic logic [2:0] find_section(logic [4:0] en, logic [2:0] start);
    logic [2:0] found;
    found = SEC_NONE;
    for (int i = NumSections - 1; i >= 0; i--) begin
      if (en[i] && (3'(i) >= start)) begin
        found = 3'(i);
      end
    end
    return found;
  endfunction

endpackage

@@ hw/rtl/crd_step.sv @@
module crd_step (
  input  crd_pkg::state_t  st,
  input  logic [7:0]       data,
  output crd_pkg::state_t  st_next,
  output crd_pkg::result_t res
);

  logic [15:0] count_raw;
  logic [17:0] count_len;
  logic [17:0] payload_left;
  logic        count_done;
  logic        payload_done;
  logic [2:0]  opt_sec;
  logic [2:0]  after_sec;

  always_comb begin
    count_raw = {st.bytes_left[7:0], data};
    priority if (st.current_section == crd_pkg::SEC_STMT_COUNT) begin
      count_len = {count_raw, 2'b00};
    end else if (st.current_section == crd_pkg::SEC_MCDC) begin
      count_len = {2'b00, count_raw} + crd_pkg::MCDC_EXTRA;
    end else begin
      count_len = {2'b00, count_raw};
    end
    count_done   = (count_len == '0);
    payload_left = (st.bytes_left != '0) ? st.bytes_left - 18'd1 : '0;
    payload_done = (payload_left == '0);
    opt_sec      = crd_pkg::find_section(data[4:0], 3'd0);
    after_sec    = crd_pkg::find_section(st.enabled_sections, st.current_section + 3'd1);
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st.mode)
      crd_pkg::MODE_NAME: begin
        if (data == 8'd0) begin
          st_next.mode = crd_pkg::MODE_OPTIONS;
        end
      end
      crd_pkg::MODE_OPTIONS: begin
        st_next.enabled_sections = data[4:0];
        st_next.bytes_left       = '0;
        if (opt_sec != crd_pkg::SEC_NONE) begin
          st_next.mode             = crd_pkg::MODE_COUNT;
          st_next.current_section  = opt_sec;
          st_next.count_bytes_left = crd_pkg::CNT_HI;
        end else begin
          st_next.mode             = crd_pkg::MODE_NAME;
          st_next.current_section  = crd_pkg::SEC_STMT_SINGLE;
          st_next.count_bytes_left = '0;
        end
      end
      crd_pkg::MODE_COUNT: begin
        if (st.count_bytes_left == crd_pkg::CNT_HI) begin
          st_next.bytes_left       = {10'd0, data};
          st_next.count_bytes_left = crd_pkg::CNT_LO;
        end else begin
          st_next.bytes_left       = count_len;
          st_next.count_bytes_left = '0;
          if (!count_done) begin
            st_next.mode = crd_pkg::MODE_PAYLOAD;
          end
        end
      end
      crd_pkg::MODE_PAYLOAD: begin
        st_next.bytes_left = payload_left;
      end
      default: begin
        st_next = st;
      end
    endcase
    // section closed: open the next one or end the record
    if (res.section_end) begin
      st_next.bytes_left = '0;
      if (after_sec != crd_pkg::SEC_NONE) begin
        st_next.mode             = crd_pkg::MODE_COUNT;
        st_next.current_section  = after_sec;
        st_next.count_bytes_left = crd_pkg::CNT_HI;
      end else begin
        st_next.mode             = crd_pkg::MODE_NAME;
        st_next.current_section  = crd_pkg::SEC_STMT_SINGLE;
        st_next.count_bytes_left = '0;
      end
    end
  end

  // tags
  always_comb begin
    res.byte_out    = data;
    res.phase       = crd_pkg::PH_NAME;
    res.section     = crd_pkg::SEC_STMT_SINGLE;
    res.section_end = 1'b0;
    res.record_end  = 1'b0;
    unique case (st.mode)
      crd_pkg::MODE_NAME: begin
        res.phase = (data == 8'd0) ? crd_pkg::PH_NAME_END : crd_pkg::PH_NAME;
      end
      crd_pkg::MODE_OPTIONS: begin
        res.phase      = crd_pkg::PH_OPTIONS;
        res.record_end = (opt_sec == crd_pkg::SEC_NONE);
      end
      crd_pkg::MODE_COUNT: begin
        res.section = st.current_section;
        if (st.count_bytes_left == crd_pkg::CNT_HI) begin
          res.phase = crd_pkg::PH_COUNT_HI;
        end else begin
          res.phase       = crd_pkg::PH_COUNT_LO;
          res.section_end = count_done;
        end
      end
      crd_pkg::MODE_PAYLOAD: begin
        res.phase       = crd_pkg::PH_PAYLOAD;
        res.section     = st.current_section;
        res.section_end = payload_done;
      end
      default: begin
        res.phase = crd_pkg::PH_NAME;
      end
    endcase
    if (res.section_end) begin
      res.record_end = (after_sec == crd_pkg::SEC_NONE);
    end
  end

endmodule

@@ hw/rtl/coverage_record_deframer_core.sv @@
// Coverage record deframer.
// Input channel: data_byte with in_valid / in_stall, one byte of the record
// stream per item. Output channel: byte_out, phase, section, section_end and
// record_end with out_valid / out_stall, one tagged item per input byte.
// Records are a zero-terminated name, an options byte, then for each enabled
// section a big-endian 16-bit count and its payload bytes.
// Path: an accepted byte goes into the input register, then through the tagging
// logic into the result register, which drives out_valid; a receiver stall
// can hold it in the input register in between.
// Throughput: one byte per cycle unless the receiver stalls; tagging and
// the next-section priority encode are combinational between two registers.
// Reset (rst, synchronous) empties both registers and returns the parser to
// waiting for a name.
// When the receiver stalls, the result register holds; the input register
// keeps its byte, and in_stall rises only once both registers are full, so
// one byte is still taken while a result waits.
module coverage_record_deframer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic [2:0] phase,
  output logic [2:0] section,
  output logic       section_end,
  output logic       record_end
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic             out_full;
  crd_pkg::result_t out_res;
  crd_pkg::state_t  st;
  crd_pkg::state_t  st_next;
  crd_pkg::result_t res_next;
  logic             out_free;
  logic             advance;

  crd_step u_step (
    .st      (st),
    .data    (in_byte),
    .st_next (st_next),
    .res     (res_next)
  );

  assign out_free = !out_full || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
      st.mode             <= crd_pkg::MODE_NAME;
      st.count_bytes_left <= '0;
      st.bytes_left       <= '0;
      st.enabled_sections <= '0;
      st.current_section  <= crd_pkg::SEC_STMT_SINGLE;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_full <= 1'b1;
        st       <= st_next;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign out_valid   = out_full;
  assign byte_out    = out_res.byte_out;
  assign phase       = out_res.phase;
  assign section     = out_res.section;
  assign section_end = out_res.section_end;
  assign record_end  = out_res.record_end;

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_full))
    else $error("input stalled with a free register");

  a_record_end_cause: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_end) |-> (section_end || phase == crd_pkg::PH_OPTIONS))
    else $error("record end without a closing byte");

  a_section_end_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && section_end) |->
      (phase == crd_pkg::PH_COUNT_LO || phase == crd_pkg::PH_PAYLOAD))
    else $error("section end outside count or payload");

  a_mode_after_record: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.record_end) |=> (st.mode == crd_pkg::MODE_NAME))
    else $error("parser did not return to name after record end");

  a_name_section_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase == crd_pkg::PH_NAME || phase == crd_pkg::PH_NAME_END
      || phase == crd_pkg::PH_OPTIONS)) |-> (section == crd_pkg::SEC_STMT_SINGLE))
    else $error("section tag set outside a section");

endmodule
